>>> hw/rtl/hcbd_pkg.sv
// hcbd_pkg: types, codes and constants for the chunked body decoder
// no dependencies; imported by http_chunked_body_decoder_unit

package hcbd_pkg;

    // size line limits
    localparam int unsigned SIZE_LINE_LIMIT = 6;
    localparam int unsigned MAX_DIGITS      = 4;

    // field widths
    localparam int unsigned BODY_W  = 29;
    localparam int unsigned CHUNK_W = 16;
    localparam int unsigned LINE_W  = 3;
    localparam int unsigned TRAIL_W = 2;

    // register file
    localparam int unsigned ADDR_W = 3;
    localparam int unsigned DATA_W = 32;
    localparam logic [BODY_W-1:0] MAX_BODY_RESET = 29'd8388608;

    // characters
    localparam logic [7:0] CHAR_CR = 8'h0d;
    localparam logic [7:0] CHAR_LF = 8'h0a;

    // input kinds
    localparam logic [1:0] IN_BYTE  = 2'd0;
    localparam logic [1:0] IN_START = 2'd1;
    localparam logic [1:0] IN_CLOSE = 2'd2;

    // result kinds
    localparam logic [1:0] OUT_BYTE = 2'd0;
    localparam logic [1:0] OUT_DONE = 2'd1;
    localparam logic [1:0] OUT_ERR  = 2'd2;

    // error codes
    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_LINE  = 2'd1;
    localparam logic [1:0] ERR_LIMIT = 2'd2;
    localparam logic [1:0] ERR_CLOSE = 2'd3;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_SIZE  = 3'd1,
        PH_DATA  = 3'd2,
        PH_TRAIL = 3'd3,
        PH_DONE  = 3'd4,
        PH_FAIL  = 3'd5
    } t_phase;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] in_byte;
    } t_item;

    typedef struct packed {
        logic [1:0]        out_kind;
        logic [7:0]        payload;
        logic [1:0]        error_code;
        logic [BODY_W-1:0] body_length;
    } t_result;

    // hex digit decode: bit 4 is valid, bits 3:0 the value
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h57)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        return r;
    endfunction

endpackage

>>> hw/rtl/http_chunked_body_decoder_unit.sv
// http_chunked_body_decoder_unit: chunked body decoder, one byte per cycle
// depends on hcbd_pkg (types, codes, hex decode)
//
//  channel   direction  handshake                    payload
//  input     in         i_in_valid / o_in_ready      i_in_item  (t_item)
//  result    out        o_out_valid / i_out_ready    o_out_item (t_result)
//  config    in/out     psel penable pwrite pready   paddr pwdata prdata
//
// one item per cycle: state updates in the cycle the item is accepted and the
// result lands in the output register at the same edge.
// the output register sets the rate under stall: a new item is taken whenever
// the output register is empty or being drained in the same cycle.
// synchronous active-low reset clears decoder state and sets the body limit
// to 8388608; no clearing pass is needed.

module http_chunked_body_decoder_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  hcbd_pkg::t_item              i_in_item,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output hcbd_pkg::t_result            o_out_item,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [hcbd_pkg::ADDR_W-1:0]  paddr,
    input  logic [hcbd_pkg::DATA_W-1:0]  pwdata,
    output logic [hcbd_pkg::DATA_W-1:0]  prdata,
    output logic                         pready
);
    import hcbd_pkg::*;

    // state
    t_phase              r_phase, n_phase;
    logic [CHUNK_W-1:0]  r_size_accum, n_size_accum;
    logic [LINE_W-1:0]   r_line_count, n_line_count;
    logic                r_cr_seen, n_cr_seen;
    logic [CHUNK_W-1:0]  r_chunk_left, n_chunk_left;
    logic [TRAIL_W-1:0]  r_trailer_left, n_trailer_left;
    logic [BODY_W-1:0]   r_bytes_delivered, n_bytes_delivered;
    logic                r_final_chunk, n_final_chunk;
    logic [BODY_W-1:0]   r_max_body;

    // output register
    logic                r_out_valid, n_out_valid;
    t_result             r_out, n_out;

    logic                w_accept;
    logic                w_is_lf, w_is_cr;
    logic [4:0]          w_hex;
    logic                w_line_full;
    logic                w_over;
    logic [BODY_W:0]     w_sum;
    logic                w_size_err;
    logic [CHUNK_W-1:0]  w_chunk_dec;
    logic [TRAIL_W-1:0]  w_trail_dec;
    logic [BODY_W-1:0]   w_bytes_inc;
    logic                w_active;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign w_accept    = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // configuration port
    assign pready = 1'b1;
    assign prdata = (paddr[ADDR_W-1:2] == '0) ? DATA_W'(r_max_body) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_body <= MAX_BODY_RESET;
        end else if (psel && penable && pwrite && pready && paddr[ADDR_W-1:2] == '0) begin
            r_max_body <= pwdata[BODY_W-1:0];
        end
    end

    // size line decode
    assign w_is_lf     = (i_in_item.in_byte == CHAR_LF);
    assign w_is_cr     = (i_in_item.in_byte == CHAR_CR);
    assign w_hex       = hex_decode(i_in_item.in_byte);
    assign w_line_full = (4'({1'b0, r_line_count}) + 4'd1) >= 4'(SIZE_LINE_LIMIT);
    assign w_sum       = (BODY_W+1)'(r_size_accum) + (BODY_W+1)'(r_bytes_delivered);
    assign w_over      = w_sum > (BODY_W+1)'(r_max_body);

    always_comb begin
        if (w_is_lf) begin
            w_size_err = !r_cr_seen || r_line_count == '0;
        end else if (w_line_full) begin
            w_size_err = 1'b1;
        end else if (w_is_cr) begin
            w_size_err = r_cr_seen;
        end else begin
            w_size_err = r_cr_seen || !w_hex[4] || r_line_count >= LINE_W'(MAX_DIGITS);
        end
    end

    // counters
    assign w_chunk_dec = r_chunk_left - CHUNK_W'(1);
    assign w_trail_dec = r_trailer_left - TRAIL_W'(1);
    assign w_bytes_inc = r_bytes_delivered + BODY_W'(1);
    assign w_active    = r_phase inside {PH_SIZE, PH_DATA, PH_TRAIL};

    // next state
    always_comb begin
        n_phase           = r_phase;
        n_size_accum      = r_size_accum;
        n_line_count      = r_line_count;
        n_cr_seen         = r_cr_seen;
        n_chunk_left      = r_chunk_left;
        n_trailer_left    = r_trailer_left;
        n_bytes_delivered = r_bytes_delivered;
        n_final_chunk     = r_final_chunk;
        if (w_accept) begin
            case (i_in_item.kind)
                IN_START: begin
                    n_phase           = PH_SIZE;
                    n_size_accum      = '0;
                    n_line_count      = '0;
                    n_cr_seen         = 1'b0;
                    n_chunk_left      = '0;
                    n_trailer_left    = '0;
                    n_bytes_delivered = '0;
                    n_final_chunk     = 1'b0;
                end
                IN_CLOSE: begin
                    if (w_active) begin
                        n_phase = PH_FAIL;
                    end
                end
                IN_BYTE: begin
                    case (r_phase)
                        PH_SIZE: begin
                            if (w_size_err || (w_is_lf && w_over)) begin
                                n_phase = PH_FAIL;
                            end else if (w_is_lf) begin
                                if (r_size_accum == '0) begin
                                    n_final_chunk  = 1'b1;
                                    n_trailer_left = TRAIL_W'(2);
                                    n_phase        = PH_TRAIL;
                                end else begin
                                    n_chunk_left = r_size_accum;
                                    n_phase      = PH_DATA;
                                end
                            end else if (w_is_cr) begin
                                n_cr_seen = 1'b1;
                            end else begin
                                n_size_accum = {r_size_accum[CHUNK_W-5:0], w_hex[3:0]};
                                n_line_count = r_line_count + LINE_W'(1);
                            end
                        end
                        PH_DATA: begin
                            n_bytes_delivered = w_bytes_inc;
                            n_chunk_left      = w_chunk_dec;
                            if (w_chunk_dec == '0) begin
                                n_final_chunk  = 1'b0;
                                n_trailer_left = TRAIL_W'(2);
                                n_phase        = PH_TRAIL;
                            end
                        end
                        PH_TRAIL: begin
                            n_trailer_left = w_trail_dec;
                            if (w_trail_dec == '0) begin
                                if (r_final_chunk) begin
                                    n_phase = PH_DONE;
                                end else begin
                                    n_phase      = PH_SIZE;
                                    n_size_accum = '0;
                                    n_line_count = '0;
                                    n_cr_seen    = 1'b0;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                default: begin
                end
            endcase
        end
    end

    // result for the accepted item
    always_comb begin
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        if (w_accept) begin
            n_out_valid            = 1'b0;
            n_out.out_kind         = OUT_ERR;
            n_out.payload          = '0;
            n_out.error_code       = ERR_NONE;
            n_out.body_length      = r_bytes_delivered;
            case (i_in_item.kind)
                IN_CLOSE: begin
                    if (w_active) begin
                        n_out_valid      = 1'b1;
                        n_out.error_code = ERR_CLOSE;
                    end
                end
                IN_BYTE: begin
                    case (r_phase)
                        PH_SIZE: begin
                            if (w_size_err) begin
                                n_out_valid      = 1'b1;
                                n_out.error_code = ERR_LINE;
                            end else if (w_is_lf && w_over) begin
                                n_out_valid      = 1'b1;
                                n_out.error_code = ERR_LIMIT;
                            end
                        end
                        PH_DATA: begin
                            n_out_valid       = 1'b1;
                            n_out.out_kind    = OUT_BYTE;
                            n_out.payload     = i_in_item.in_byte;
                            n_out.body_length = w_bytes_inc;
                        end
                        PH_TRAIL: begin
                            if (w_trail_dec == '0 && r_final_chunk) begin
                                n_out_valid    = 1'b1;
                                n_out.out_kind = OUT_DONE;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                default: begin
                end
            endcase
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase           <= PH_IDLE;
            r_size_accum      <= '0;
            r_line_count      <= '0;
            r_cr_seen         <= 1'b0;
            r_chunk_left      <= '0;
            r_trailer_left    <= '0;
            r_bytes_delivered <= '0;
            r_final_chunk     <= 1'b0;
            r_out_valid       <= 1'b0;
        end else begin
            r_phase           <= n_phase;
            r_size_accum      <= n_size_accum;
            r_line_count      <= n_line_count;
            r_cr_seen         <= n_cr_seen;
            r_chunk_left      <= n_chunk_left;
            r_trailer_left    <= n_trailer_left;
            r_bytes_delivered <= n_bytes_delivered;
            r_final_chunk     <= n_final_chunk;
            r_out_valid       <= n_out_valid;
        end
    end

    // result payload register
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

endmodule
